@@ rtl/wavd_pkg.sv @@
// ----------------------------------------------------------------------------
// wavd_pkg
// Shared types, tag constants and status codes for the wav header deframer.
// ----------------------------------------------------------------------------
package wavd_pkg;

    localparam int HDR_LEN = 12;
    localparam int FMT_LEN = 16;

    // four-byte tags, first character in the lowest byte
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] RATE_LOW     = 32'd4000;
    localparam logic [31:0] RATE_HIGH    = 32'd20000;
    localparam logic [31:0] RATE_DEFAULT = 32'd8000;

    localparam logic [2:0] ST_PARSE = 3'd0;
    localparam logic [2:0] ST_WAV   = 3'd1;
    localparam logic [2:0] ST_RAW   = 3'd2;
    localparam logic [2:0] ST_BAD   = 3'd3;
    localparam logic [2:0] ST_RATE  = 3'd4;

    typedef enum logic [7:0] {
        PH_COLLECT = 8'b0000_0001,
        PH_CHDR    = 8'b0000_0010,
        PH_FMT     = 8'b0000_0100,
        PH_SKIP    = 8'b0000_1000,
        PH_PAD     = 8'b0001_0000,
        PH_PLAY    = 8'b0010_0000,
        PH_STOP    = 8'b0100_0000,
        PH_FLUSH   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic        last;
        logic        valid;
        logic [7:0]  sample;
        logic [2:0]  status;
        logic [31:0] rate;
    } result_t;

    typedef struct packed {
        logic       we;
        logic [3:0] addr;
        logic [7:0] data;
    } hdr_wr_t;

    function automatic logic rate_ok(input logic [31:0] r);
        return (r >= RATE_LOW) && (r <= RATE_HIGH);
    endfunction

    function automatic result_t make_res(input logic valid, input logic [7:0] data,
                                         input logic [2:0] st, input logic [31:0] rate,
                                         input logic last);
        result_t r;
        r.last   = last;
        r.valid  = valid;
        r.sample = valid ? data : 8'd0;
        r.status = st;
        r.rate   = (st == ST_WAV || st == ST_RAW) ? rate : 32'd0;
        return r;
    endfunction

endpackage

@@ rtl/wavd_hdr_store.sv @@
// ----------------------------------------------------------------------------
// wavd_hdr_store
// Twelve-byte header hold with tag match and a read port for the raw flush.
// ----------------------------------------------------------------------------
module wavd_hdr_store (
    input  logic             aclk,
    input  wavd_pkg::hdr_wr_t wr,
    input  logic [3:0]       raddr,
    output logic [7:0]       rdata,
    output logic             riff_ok,
    output logic             wav_ok
);
    import wavd_pkg::*;

    logic [7:0] mem_reg [HDR_LEN];

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    assign rdata   = mem_reg[raddr];
    assign riff_ok = ({mem_reg[3], mem_reg[2], mem_reg[1], mem_reg[0]} == TAG_RIFF);
    // last byte of the wave tag arrives with the word that completes the header
    assign wav_ok  = ({mem_reg[10], mem_reg[9], mem_reg[8]} == TAG_WAVE[23:0]);

endmodule

@@ rtl/wavd_parser.sv @@
// ----------------------------------------------------------------------------
// wavd_parser
// Chunk walker: header collect, chunk headers, fmt check, skip, pad, play, stop and flush.
// ----------------------------------------------------------------------------
module wavd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_end,
    input  logic              cfg_we,
    input  logic [19:0]       cfg_data,
    input  logic              buf_ready,
    output logic              res_valid,
    output wavd_pkg::result_t res,
    output wavd_pkg::hdr_wr_t hdr_wr,
    output logic [3:0]        hdr_raddr,
    input  logic [7:0]        hdr_rdata,
    input  logic              riff_ok,
    input  logic              wav_ok
);
    import wavd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hcount_reg, hcount_next;
    logic [31:0] chunk_id_reg, chunk_id_next;
    logic [31:0] chunk_size_reg, chunk_size_next;
    logic [31:0] bcount_reg, bcount_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [31:0] rate_reg, rate_next;
    logic [2:0]  held_reg, held_next;
    logic [3:0]  fl_idx_reg, fl_idx_next;
    logic [3:0]  fl_len_reg, fl_len_next;
    logic        fl_play_reg, fl_play_next;
    logic [19:0] req_rate_reg;
    logic [7:0]  fmt_reg [FMT_LEN];
    logic        fmt_we;

    logic        accept;
    logic [31:0] raw_rate;
    logic        fl_last;
    logic [31:0] cnt_dec;
    logic [31:0] fmt_rem;
    logic        fmt_good;

    function automatic phase_t after_body(input logic [31:0] cnt, input logic odd);
        if (cnt != 32'd0) begin
            return PH_SKIP;
        end else if (odd) begin
            return PH_PAD;
        end
        return PH_CHDR;
    endfunction

    assign in_ready  = buf_ready && (phase_reg != PH_FLUSH);
    assign accept    = in_valid && in_ready;
    assign raw_rate  = rate_ok({12'd0, req_rate_reg}) ? {12'd0, req_rate_reg} : RATE_DEFAULT;
    assign hdr_raddr = fl_idx_reg;
    assign fl_last   = (fl_idx_reg == 4'(fl_len_reg - 4'd1));
    assign cnt_dec   = bcount_reg - 32'd1;
    assign fmt_rem   = chunk_size_reg - 32'(FMT_LEN);
    assign fmt_good  = (fmt_reg[0] == 8'd1) && (fmt_reg[1] == 8'd0) &&
                       (fmt_reg[2] == 8'd1) && (fmt_reg[3] == 8'd0) &&
                       (fmt_reg[14] == 8'd8) && (in_byte == 8'd0);

    always_comb begin
        phase_next      = phase_reg;
        hcount_next     = hcount_reg;
        chunk_id_next   = chunk_id_reg;
        chunk_size_next = chunk_size_reg;
        bcount_next     = bcount_reg;
        fmt_seen_next   = fmt_seen_reg;
        rate_next       = rate_reg;
        held_next       = held_reg;
        fl_idx_next     = fl_idx_reg;
        fl_len_next     = fl_len_reg;
        fl_play_next    = fl_play_reg;
        fmt_we          = 1'b0;
        hdr_wr.we       = 1'b0;
        hdr_wr.addr     = hcount_reg;
        hdr_wr.data     = in_byte;
        res_valid       = 1'b0;
        res             = make_res(1'b0, 8'd0, ST_PARSE, 32'd0, 1'b1);

        case (phase_reg)
            PH_COLLECT: begin
                if (accept) begin
                    if (in_end) begin
                        rate_next = raw_rate;
                        held_next = ST_RAW;
                        if (hcount_reg == 4'd0) begin
                            phase_next = PH_STOP;
                            res_valid  = 1'b1;
                            res        = make_res(1'b0, 8'd0, ST_RAW, raw_rate, 1'b1);
                        end else begin
                            phase_next   = PH_FLUSH;
                            fl_idx_next  = 4'd0;
                            fl_len_next  = hcount_reg;
                            fl_play_next = 1'b0;
                        end
                    end else begin
                        hdr_wr.we   = 1'b1;
                        hcount_next = hcount_reg + 4'd1;
                        if (hcount_reg == 4'(HDR_LEN - 1)) begin
                            if (riff_ok && wav_ok && in_byte == TAG_WAVE[31:24]) begin
                                phase_next      = PH_CHDR;
                                bcount_next     = 32'd0;
                                chunk_id_next   = 32'd0;
                                chunk_size_next = 32'd0;
                                res_valid       = 1'b1;
                            end else begin
                                // header is not riff/wave: release it as raw samples
                                rate_next    = raw_rate;
                                held_next    = ST_RAW;
                                phase_next   = PH_FLUSH;
                                fl_idx_next  = 4'd0;
                                fl_len_next  = 4'(HDR_LEN);
                                fl_play_next = 1'b1;
                            end
                        end else begin
                            res_valid = 1'b1;
                        end
                    end
                end
            end
            PH_CHDR: begin
                if (accept) begin
                    res_valid = 1'b1;
                    if (in_end) begin
                        held_next  = ST_BAD;
                        phase_next = PH_STOP;
                        res        = make_res(1'b0, 8'd0, ST_BAD, rate_reg, 1'b1);
                    end else begin
                        if (!bcount_reg[2]) begin
                            chunk_id_next[{bcount_reg[1:0], 3'b000} +: 8] = in_byte;
                        end else begin
                            chunk_size_next[{bcount_reg[1:0], 3'b000} +: 8] = in_byte;
                        end
                        bcount_next = bcount_reg + 32'd1;
                        if (bcount_reg[2:0] == 3'd7) begin
                            if (chunk_id_reg == TAG_FMT) begin
                                if (chunk_size_next < 32'(FMT_LEN)) begin
                                    held_next  = ST_BAD;
                                    phase_next = PH_STOP;
                                    res = make_res(1'b0, 8'd0, ST_BAD, rate_reg, 1'b1);
                                end else begin
                                    phase_next  = PH_FMT;
                                    bcount_next = 32'd0;
                                end
                            end else if (chunk_id_reg == TAG_DATA) begin
                                if (!fmt_seen_reg) begin
                                    held_next  = ST_BAD;
                                    phase_next = PH_STOP;
                                    res = make_res(1'b0, 8'd0, ST_BAD, rate_reg, 1'b1);
                                end else if (!rate_ok(rate_reg)) begin
                                    held_next  = ST_RATE;
                                    phase_next = PH_STOP;
                                    res = make_res(1'b0, 8'd0, ST_RATE, rate_reg, 1'b1);
                                end else begin
                                    held_next  = ST_WAV;
                                    phase_next = PH_PLAY;
                                    res = make_res(1'b0, 8'd0, ST_WAV, rate_reg, 1'b1);
                                end
                            end else begin
                                bcount_next = chunk_size_next;
                                phase_next  = after_body(chunk_size_next, chunk_size_next[0]);
                                if (phase_next == PH_CHDR) begin
                                    chunk_id_next   = 32'd0;
                                    chunk_size_next = 32'd0;
                                end
                            end
                        end
                    end
                end
            end
            PH_FMT: begin
                if (accept) begin
                    res_valid = 1'b1;
                    if (in_end) begin
                        held_next  = ST_BAD;
                        phase_next = PH_STOP;
                        res        = make_res(1'b0, 8'd0, ST_BAD, rate_reg, 1'b1);
                    end else begin
                        fmt_we      = 1'b1;
                        bcount_next = bcount_reg + 32'd1;
                        if (bcount_reg[3:0] == 4'(FMT_LEN - 1)) begin
                            if (!fmt_good) begin
                                held_next  = ST_BAD;
                                phase_next = PH_STOP;
                                res = make_res(1'b0, 8'd0, ST_BAD, rate_reg, 1'b1);
                            end else begin
                                rate_next     = {fmt_reg[7], fmt_reg[6], fmt_reg[5], fmt_reg[4]};
                                fmt_seen_next = 1'b1;
                                bcount_next   = fmt_rem;
                                phase_next    = after_body(fmt_rem, chunk_size_reg[0]);
                                if (phase_next == PH_CHDR) begin
                                    chunk_id_next   = 32'd0;
                                    chunk_size_next = 32'd0;
                                end
                            end
                        end
                    end
                end
            end
            PH_SKIP: begin
                if (accept) begin
                    res_valid = 1'b1;
                    if (in_end) begin
                        held_next  = ST_BAD;
                        phase_next = PH_STOP;
                        res        = make_res(1'b0, 8'd0, ST_BAD, rate_reg, 1'b1);
                    end else begin
                        bcount_next = cnt_dec;
                        phase_next  = after_body(cnt_dec, chunk_size_reg[0]);
                        if (phase_next == PH_CHDR) begin
                            chunk_id_next   = 32'd0;
                            chunk_size_next = 32'd0;
                        end
                    end
                end
            end
            PH_PAD: begin
                if (accept) begin
                    res_valid = 1'b1;
                    if (in_end) begin
                        held_next  = ST_BAD;
                        phase_next = PH_STOP;
                        res        = make_res(1'b0, 8'd0, ST_BAD, rate_reg, 1'b1);
                    end else begin
                        phase_next      = PH_CHDR;
                        bcount_next     = 32'd0;
                        chunk_id_next   = 32'd0;
                        chunk_size_next = 32'd0;
                    end
                end
            end
            PH_PLAY: begin
                if (accept) begin
                    res_valid = 1'b1;
                    if (in_end) begin
                        phase_next = PH_STOP;
                        res        = make_res(1'b0, 8'd0, held_reg, rate_reg, 1'b1);
                    end else begin
                        res        = make_res(1'b1, in_byte, held_reg, rate_reg, 1'b1);
                    end
                end
            end
            PH_STOP: begin
                if (accept) begin
                    res_valid = 1'b1;
                    res       = make_res(1'b0, 8'd0, held_reg, rate_reg, 1'b1);
                end
            end
            PH_FLUSH: begin
                if (buf_ready) begin
                    res_valid   = 1'b1;
                    res         = make_res(1'b1, hdr_rdata, ST_RAW, rate_reg, fl_last);
                    fl_idx_next = fl_idx_reg + 4'd1;
                    if (fl_last) begin
                        phase_next = fl_play_reg ? PH_PLAY : PH_STOP;
                    end
                end
            end
            default: begin
                phase_next = PH_STOP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_COLLECT;
            hcount_reg     <= 4'd0;
            chunk_id_reg   <= 32'd0;
            chunk_size_reg <= 32'd0;
            bcount_reg     <= 32'd0;
            fmt_seen_reg   <= 1'b0;
            rate_reg       <= 32'd0;
            held_reg       <= ST_PARSE;
            fl_idx_reg     <= 4'd0;
            fl_len_reg     <= 4'd0;
            fl_play_reg    <= 1'b0;
            req_rate_reg   <= RATE_DEFAULT[19:0];
        end else begin
            phase_reg      <= phase_next;
            hcount_reg     <= hcount_next;
            chunk_id_reg   <= chunk_id_next;
            chunk_size_reg <= chunk_size_next;
            bcount_reg     <= bcount_next;
            fmt_seen_reg   <= fmt_seen_next;
            rate_reg       <= rate_next;
            held_reg       <= held_next;
            fl_idx_reg     <= fl_idx_next;
            fl_len_reg     <= fl_len_next;
            fl_play_reg    <= fl_play_next;
            if (cfg_we) begin
                req_rate_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fmt_we) begin
            fmt_reg[bcount_reg[3:0]] <= in_byte;
        end
    end

endmodule

@@ rtl/wavd_out_buf.sv @@
// ----------------------------------------------------------------------------
// wavd_out_buf
// Two-entry result buffer; its ready comes straight from a register.
// ----------------------------------------------------------------------------
module wavd_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  wavd_pkg::result_t in_res,
    output logic              out_valid,
    input  logic              out_ready,
    output wavd_pkg::result_t out_res
);
    import wavd_pkg::*;

    result_t    slot0_reg, slot1_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_res   = slot0_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (count_reg == 2'd2) begin
            if (pop) begin
                slot0_reg <= slot1_reg;
            end
        end else if (count_reg == 2'd1) begin
            if (push && pop) begin
                slot0_reg <= in_res;
            end else if (push) begin
                slot1_reg <= in_res;
            end
        end else begin
            if (push) begin
                slot0_reg <= in_res;
            end
        end
    end

endmodule

@@ rtl/wav_header_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// wav_header_deframer_unit
// Strips a riff/wav header from an 8-bit mono audio byte stream.
// ----------------------------------------------------------------------------
// Input words on the s_ channel carry one stream byte each; s_tlast marks the
// end of the stream and carries no byte. Every input word gives one result word
// on the m_ channel, with a sample flag on m_tuser and m_tlast on the final
// result of that word. Two cases give several results: the twelfth byte of a
// stream whose header is not riff/wave releases all twelve held bytes as raw
// samples, and an end mark before twelve bytes releases the bytes held so far.
// Throughput is one word per cycle while the output buffer has room; during a
// header release s_tready stays low while the held bytes (up to 12) are read
// one at a time from the header hold. Results pass through a two-word buffer,
// so a stalled receiver holds back s_tready only once that buffer is full.
// cfg_wr_en writes the requested raw-stream rate; write it only while idle.
// Reset (aresetn low, synchronous) empties the buffer, returns the parser to
// header collection and sets the requested rate to 8000.
// ----------------------------------------------------------------------------
module wav_header_deframer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,     // end_mark
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // [7:0] sample_byte, [10:8] status, [42:11] sample_rate
    output logic        m_tuser,     // sample_valid
    output logic        m_tlast,     // run_last
    input  logic        cfg_wr_en,
    input  logic [19:0] cfg_wr_data
);
    import wavd_pkg::*;

    hdr_wr_t    hdr_wr;
    logic [3:0] hdr_raddr;
    logic [7:0] hdr_rdata;
    logic       riff_ok, wav_ok;
    logic       buf_ready, res_valid;
    result_t    res, out_res;

    wavd_hdr_store u_hdr (
        .aclk    (aclk),
        .wr      (hdr_wr),
        .raddr   (hdr_raddr),
        .rdata   (hdr_rdata),
        .riff_ok (riff_ok),
        .wav_ok  (wav_ok)
    );

    wavd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .cfg_we    (cfg_wr_en),
        .cfg_data  (cfg_wr_data),
        .buf_ready (buf_ready),
        .res_valid (res_valid),
        .res       (res),
        .hdr_wr    (hdr_wr),
        .hdr_raddr (hdr_raddr),
        .hdr_rdata (hdr_rdata),
        .riff_ok   (riff_ok),
        .wav_ok    (wav_ok)
    );

    wavd_out_buf u_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (buf_ready),
        .in_res    (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {5'd0, out_res.rate, out_res.status, out_res.sample};
    assign m_tuser = out_res.valid;
    assign m_tlast = out_res.last;

endmodule

@@ rtl/wavd_checker.sv @@
// ----------------------------------------------------------------------------
// wavd_checker
// Port-level checks on the result channel of the deframer.
// ----------------------------------------------------------------------------
module wavd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);
    import wavd_pkg::*;

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word present straight after reset");

    // a sample only ever goes out while playing
    a_sample_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[10:8] == ST_WAV || m_tdata[10:8] == ST_RAW))
        else $error("sample word outside a playing status");

    // rate is only shown while playing
    a_rate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10:8] != ST_WAV && m_tdata[10:8] != ST_RAW
        |-> m_tdata[42:11] == 32'd0)
        else $error("rate shown outside a playing status");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

endmodule

bind wav_header_deframer_unit wavd_checker u_wavd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
